// File: rtl/rgb_color_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// rgb_color_classifier_core_macros.svh
// Assertion shorthands shared by the checker of the color classifier.
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_CLASSIFIER_CORE_MACROS_SVH
`define RGB_COLOR_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types and constants of the RGB color classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned ClassW = 4;
	localparam int unsigned CfgIdxW = 3;

	// Wide enough for 100*count + 15*(r+g+b) without overflow.
	localparam int unsigned ProdW = 25;

	typedef enum logic [ClassW-1:0] {
		CLS_NONE    = 4'd0,
		CLS_ORANGE  = 4'd1,
		CLS_RED     = 4'd2,
		CLS_GOLD    = 4'd3,
		CLS_YELLOW  = 4'd4,
		CLS_GREEN   = 4'd5,
		CLS_BLUE    = 4'd6,
		CLS_VIOLET  = 4'd7,
		CLS_WHITE   = 4'd8,
		CLS_SILVER  = 4'd9,
		CLS_GREY    = 4'd10,
		CLS_UNKNOWN = 4'd11
	} color_class_t;

	localparam logic [CfgIdxW-1:0] CFG_DARK   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_GOLD   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_WHITE  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_SILVER = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_GREY   = 3'd4;

	localparam logic [CountW-1:0] DARK_RST   = 16'd30;
	localparam logic [CountW-1:0] GOLD_RST   = 16'd400;
	localparam logic [CountW-1:0] WHITE_RST  = 16'd600;
	localparam logic [CountW-1:0] SILVER_RST = 16'd300;
	localparam logic [CountW-1:0] GREY_RST   = 16'd80;

endpackage

`default_nettype wire

// File: rtl/rgb_color_classifier_core.sv
// ----------------------------------------------------------------------------
// rgb_color_classifier_core
// Classifies one color-sensor reading (red, green, blue, clear) per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries one reading per beat:
//   red_count, green_count, blue_count, clear_count. Output channel
//   (result_valid / result_stall) returns one color_class per reading, in
//   order. Thresholds are written through cfg_we / cfg_index / cfg_data while
//   the block is idle; indexes above the last register are ignored.
//   Path: an accepted input beat is registered in the input register, classified
//   combinationally, and registered in the result register once that register
//   is free; the result beat then leaves when the receiver does not stall.
//   Throughput: one reading per cycle unless the receiver stalls, set by the
//   single compare stage between the input and result registers.
//   Reset: arst_n clears both stage valids and loads the threshold defaults.
//   Stall: a stalled result holds; the input register still takes one more
//   beat, and item_stall rises only when both stages are full and the
//   receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_color_classifier_core
	import rcc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               item_valid,
	output      logic               item_stall,
	input  wire logic [CountW-1:0]  red_count,
	input  wire logic [CountW-1:0]  green_count,
	input  wire logic [CountW-1:0]  blue_count,
	input  wire logic [CountW-1:0]  clear_count,

	output      logic               result_valid,
	input  wire logic               result_stall,
	output      logic [ClassW-1:0]  color_class,

	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CountW-1:0]  cfg_data
);

	// Threshold registers.
	logic [CountW-1:0] dark_thr_q;
	logic [CountW-1:0] gold_thr_q;
	logic [CountW-1:0] white_thr_q;
	logic [CountW-1:0] silver_thr_q;
	logic [CountW-1:0] grey_thr_q;

	// Input stage.
	logic              valid_s1;
	logic [CountW-1:0] red_s1;
	logic [CountW-1:0] green_s1;
	logic [CountW-1:0] blue_s1;
	logic [CountW-1:0] clear_s1;

	// Result stage.
	logic              valid_s2;
	color_class_t      class_s2;

	logic              out_free;
	logic              s1_load;
	logic              s2_load;
	color_class_t      class_next;

	// Products of the ratio and share tests, all exact integers.
	logic [ProdW-1:0] r_w, g_w, b_w, t_w;
	logic [ProdW-1:0] r100, g100, b100, g115, g85, t23, t15;
	logic [ProdW-1:0] r10, g10, b10, t4, t3;
	logic             is_dark, rg_high, rg_band, orange, dom_green, dom_blue;
	logic             violet, balanced;

	// Configuration writes: ignore indexes past the last register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_thr_q   <= DARK_RST;
			gold_thr_q   <= GOLD_RST;
			white_thr_q  <= WHITE_RST;
			silver_thr_q <= SILVER_RST;
			grey_thr_q   <= GREY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DARK:   dark_thr_q   <= cfg_data;
				CFG_GOLD:   gold_thr_q   <= cfg_data;
				CFG_WHITE:  white_thr_q  <= cfg_data;
				CFG_SILVER: silver_thr_q <= cfg_data;
				CFG_GREY:   grey_thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flow control: the result register frees up when empty or taken this
	// cycle; the input register advances whenever the result register frees.
	assign out_free   = !valid_s2 || !result_stall;
	assign s2_load    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign s1_load    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (out_free || !valid_s1) begin
			valid_s1 <= item_valid;
		end
	end

	// Capture the reading; hold while the stage is stalled.
	always_ff @(posedge clk) begin
		if (s1_load) begin
			red_s1   <= red_count;
			green_s1 <= green_count;
			blue_s1  <= blue_count;
			clear_s1 <= clear_count;
		end
	end

	// Widen the counts and form the scaled terms.
	always_comb begin
		r_w  = ProdW'(red_s1);
		g_w  = ProdW'(green_s1);
		b_w  = ProdW'(blue_s1);
		t_w  = r_w + g_w + b_w;
		r100 = r_w * ProdW'(100);
		g100 = g_w * ProdW'(100);
		b100 = b_w * ProdW'(100);
		g115 = g_w * ProdW'(115);
		g85  = g_w * ProdW'(85);
		t23  = t_w * ProdW'(23);
		t15  = t_w * ProdW'(15);
		r10  = r_w * ProdW'(10);
		g10  = g_w * ProdW'(10);
		b10  = b_w * ProdW'(10);
		t4   = t_w * ProdW'(4);
		t3   = t_w * ProdW'(3);
	end

	// Individual tests, evaluated in parallel.
	always_comb begin
		is_dark   = (clear_s1 < dark_thr_q) || (t_w == '0);
		// A zero green counts as a very large red/green ratio.
		rg_high   = (green_s1 == '0) || (r100 > g115);
		rg_band   = r100 > g85;
		orange    = b100 < t23;
		dom_green = (green_s1 > red_s1) && (green_s1 > blue_s1);
		dom_blue  = (blue_s1 > red_s1) && (blue_s1 > green_s1);
		violet    = (b10 > t4) && (r10 > t3) && (g10 < t3);
		balanced  = (r100 + t15 > g100) && (r100 < g100 + t15) &&
		            (g100 + t15 > b100) && (g100 < b100 + t15);
	end

	// Priority chain: first test that matches sets the class.
	always_comb begin
		if (is_dark) begin
			class_next = CLS_NONE;
		end else if (rg_high) begin
			class_next = orange ? CLS_ORANGE : CLS_RED;
		end else if (rg_band) begin
			class_next = (clear_s1 > gold_thr_q) ? CLS_GOLD : CLS_YELLOW;
		end else if (dom_green) begin
			class_next = CLS_GREEN;
		end else if (dom_blue) begin
			class_next = CLS_BLUE;
		end else if (violet) begin
			class_next = CLS_VIOLET;
		end else if (balanced && (clear_s1 > white_thr_q)) begin
			class_next = CLS_WHITE;
		end else if (balanced && (clear_s1 > silver_thr_q)) begin
			class_next = CLS_SILVER;
		end else if (balanced && (clear_s1 > grey_thr_q)) begin
			class_next = CLS_GREY;
		end else begin
			// Dim balanced readings land here as well.
			class_next = CLS_UNKNOWN;
		end
	end

	// Result register: drop the beat once taken, hold it while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			class_s2 <= class_next;
		end
	end

	assign result_valid = valid_s2;
	assign color_class  = class_s2;

endmodule

`default_nettype wire

// File: rtl/rcc_checker.sv
// ----------------------------------------------------------------------------
// rcc_checker
// Port-level checks of the color classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_color_classifier_core_macros.svh"

module rcc_checker
	import rcc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic [ClassW-1:0]  color_class
);

	logic item_take;

	assign item_take = item_valid && !item_stall;

	`RCC_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(color_class), "stalled result beat changed or dropped")
	`RCC_ASSERT_NOW(a_class_legal, result_valid, color_class <= CLS_UNKNOWN, "color class code out of range")
	`RCC_ASSERT_NOW(a_stall_backpressure, item_stall, result_valid && result_stall, "input stalled while output side not backed up")
	`RCC_ASSERT_NOW(a_result_latency, $rose(result_valid), $past(item_take, 2), "result appeared without an input beat two cycles before")

endmodule

bind rgb_color_classifier_core rcc_checker u_rcc_checker (.*);

`default_nettype wire
